/* rtl/ole_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered list engine package
// Shared widths, codes and the command and status types that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int LIST_DEPTH_DEF = 16;

    localparam int ACTION_W    = 2;
    localparam int POS_W       = 5;
    localparam int VALUE_W     = 32;
    localparam int TOL_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int RES_POS_W   = 4;
    localparam int COUNT_OUT_W = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BEYOND   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_TOP,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DOWN,
        WR_VALUE
    } t_wr_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_INSERT,
        RES_PTR,
        RES_HIT
    } t_res_sel;

    typedef struct packed {
        logic     load;
        t_ptr_op  ptr_op;
        t_wr_op   wr_op;
        t_cnt_op  cnt_op;
        logic     hit_cap;
        logic     res_set;
        t_status  res_status;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic beyond;
        logic full;
        logic empty;
        logic pos_at_end;
        logic match;
        logic ptr_at_pos;
        logic ptr_at_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/ole_ram.sv */
// ----------------------------------------------------------------------------
// Ordered list engine RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/ole_datapath.sv */
// ----------------------------------------------------------------------------
// Ordered list engine datapath
// Entry memory, walk pointer, entry count, tolerance compare, tolerance
// register and the output register.
// ----------------------------------------------------------------------------
module ole_datapath #(
    parameter int LIST_DEPTH = ole_pkg::LIST_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ole_pkg::t_dp_cmd                    i_cmd,
    output ole_pkg::t_dp_sts                    o_sts,
    input  logic                                i_cfg_valid,
    input  logic [ole_pkg::TOL_W-1:0]           i_cfg_match_tolerance,
    input  logic [ole_pkg::POS_W-1:0]           i_position,
    input  logic signed [ole_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ole_pkg::STATUS_W-1:0]        o_status,
    output logic [ole_pkg::RES_POS_W-1:0]       o_result_position,
    output logic [ole_pkg::COUNT_OUT_W-1:0]     o_entry_count
);

    import ole_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int WW = (POS_W > CW) ? POS_W : CW;
    localparam int DW = VALUE_W + 1;

    logic [TOL_W-1:0]   r_tol;
    logic [VALUE_W-1:0] r_value;
    logic [POS_W-1:0]   r_pos;
    logic [CW-1:0]      r_total;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      n_ptr;
    logic [AW-1:0]      r_hit;
    t_status            r_status;
    logic [AW-1:0]      r_res_pos;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [AW-1:0]      r_out_pos;
    logic [CW-1:0]      r_out_count;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [VALUE_W-1:0] rd_data;

    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] tol_pos;
    logic signed [DW-1:0] tol_neg;
    logic [CW-1:0]        total_last;
    logic [AW-1:0]        res_pos;

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_TOP:  n_ptr = AW'(r_total - CW'(1));
            PTR_ZERO: n_ptr = '0;
            PTR_INC:  n_ptr = r_ptr + AW'(1);
            PTR_DEC:  n_ptr = r_ptr - AW'(1);
            default:  n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_ptr;
        wr_data = rd_data;
        case (i_cmd.wr_op)
            WR_UP:    wr_addr = r_ptr + AW'(1);
            WR_DOWN:  wr_addr = r_ptr - AW'(1);
            WR_VALUE: begin
                wr_addr = AW'(r_pos);
                wr_data = r_value;
            end
            default:  wr_en = 1'b0;
        endcase
    end

    ole_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_ptr),
        .o_rd_data (rd_data)
    );

    assign diff    = $signed({rd_data[VALUE_W-1], rd_data})
                   - $signed({r_value[VALUE_W-1], r_value});
    assign tol_pos = $signed({{(DW-TOL_W){1'b0}}, r_tol});
    assign tol_neg = $signed(DW'(0) - {{(DW-TOL_W){1'b0}}, r_tol});
    assign total_last = r_total - CW'(1);

    always_comb begin
        case (i_cmd.res_sel)
            RES_INSERT: res_pos = AW'(r_pos);
            RES_PTR:    res_pos = r_ptr;
            RES_HIT:    res_pos = r_hit;
            default:    res_pos = '0;
        endcase
    end

    assign o_sts.beyond      = WW'(r_pos) > WW'(r_total);
    assign o_sts.full        = r_total == CW'(LIST_DEPTH);
    assign o_sts.empty       = r_total == '0;
    assign o_sts.pos_at_end  = WW'(r_pos) == WW'(r_total);
    assign o_sts.match       = (diff <= tol_pos) && (diff >= tol_neg);
    assign o_sts.ptr_at_pos  = WW'(r_ptr) == WW'(r_pos);
    assign o_sts.ptr_at_last = CW'(r_ptr) == total_last;
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= '0;
            r_total     <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tol <= i_cfg_match_tolerance;
            end
            r_ptr <= n_ptr;
            case (i_cmd.cnt_op)
                CNT_INC: r_total <= r_total + CW'(1);
                CNT_DEC: r_total <= r_total - CW'(1);
                default: r_total <= r_total;
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (i_cmd.hit_cap) begin
            r_hit <= r_ptr;
        end
        if (i_cmd.res_set) begin
            r_status  <= i_cmd.res_status;
            r_res_pos <= res_pos;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_pos    <= r_res_pos;
            r_out_count  <= r_total;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_result_position = RES_POS_W'(r_out_pos);
    assign o_entry_count     = COUNT_OUT_W'(r_out_count);

endmodule

/* rtl/ole_ctrl.sv */
// ----------------------------------------------------------------------------
// Ordered list engine controller
// State machine that takes one request at a time and steps the datapath
// through the bound checks, the search walk and the shift walks.
// ----------------------------------------------------------------------------
module ole_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ole_pkg::ACTION_W-1:0]   i_action,
    input  ole_pkg::t_dp_sts               i_sts,
    output ole_pkg::t_dp_cmd               o_cmd
);

    import ole_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_SHIFT,
        S_INS_WRITE,
        S_SCAN,
        S_DEL_SHIFT,
        S_RESULT
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [ACTION_W-1:0] r_action;
    logic [ACTION_W-1:0] n_action;

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_action   = i_action;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (r_action) inside
                    ACT_INSERT: begin
                        if (i_sts.beyond) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ST_BEYOND;
                            o_cmd.res_sel    = RES_ZERO;
                            n_state          = S_RESULT;
                        end else if (i_sts.full) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ST_FULL;
                            o_cmd.res_sel    = RES_ZERO;
                            n_state          = S_RESULT;
                        end else if (i_sts.pos_at_end) begin
                            n_state = S_INS_WRITE;
                        end else begin
                            o_cmd.ptr_op = PTR_TOP;
                            n_state      = S_INS_SHIFT;
                        end
                    end
                    ACT_FIND, ACT_DELETE: begin
                        if (i_sts.empty) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ST_NOTFOUND;
                            o_cmd.res_sel    = RES_ZERO;
                            n_state          = S_RESULT;
                        end else begin
                            o_cmd.ptr_op = PTR_ZERO;
                            n_state      = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_NOTFOUND;
                        o_cmd.res_sel    = RES_ZERO;
                        n_state          = S_RESULT;
                    end
                endcase
            end
            S_INS_SHIFT: begin
                o_cmd.wr_op = WR_UP;
                if (i_sts.ptr_at_pos) begin
                    n_state = S_INS_WRITE;
                end else begin
                    o_cmd.ptr_op = PTR_DEC;
                end
            end
            S_INS_WRITE: begin
                o_cmd.wr_op      = WR_VALUE;
                o_cmd.cnt_op     = CNT_INC;
                o_cmd.res_set    = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.res_sel    = RES_INSERT;
                n_state          = S_RESULT;
            end
            S_SCAN: begin
                if (i_sts.match) begin
                    if (r_action == ACT_DELETE) begin
                        o_cmd.hit_cap = 1'b1;
                        if (i_sts.ptr_at_last) begin
                            o_cmd.cnt_op     = CNT_DEC;
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ST_OK;
                            o_cmd.res_sel    = RES_PTR;
                            n_state          = S_RESULT;
                        end else begin
                            o_cmd.ptr_op = PTR_INC;
                            n_state      = S_DEL_SHIFT;
                        end
                    end else begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_sel    = RES_PTR;
                        n_state          = S_RESULT;
                    end
                end else if (i_sts.ptr_at_last) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_NOTFOUND;
                    o_cmd.res_sel    = RES_ZERO;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                end
            end
            S_DEL_SHIFT: begin
                o_cmd.wr_op = WR_DOWN;
                if (i_sts.ptr_at_last) begin
                    o_cmd.cnt_op     = CNT_DEC;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_sel    = RES_HIT;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_action <= '0;
        end else begin
            r_state  <= n_state;
            r_action <= n_action;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

/* rtl/ordered_list_engine.sv */
// ----------------------------------------------------------------------------
// Ordered list engine
// Keeps a bounded ordered list of signed Q16.16 values with insert at a
// position, find within a tolerance, and delete of the first match.
//
// The request channel (i_in_valid, o_in_stall) carries an action, a position
// and a value; a transfer happens when valid is high and stall is low. Each
// request gives exactly one result transfer on the output channel
// (o_out_valid, i_out_stall) with a status, a position and the entry count.
// One request is worked at a time, walking an entry RAM with one read and one
// write port one entry per cycle. The result sits in an output register, so
// the next request is taken while an earlier result is still stalled; a
// request whose result finds that register full waits until it is taken.
// The configuration channel (i_cfg_valid, o_cfg_ready) writes the match
// tolerance and is always ready. Reset empties the list and clears the
// tolerance; the entry RAM needs no clearing.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
    parameter int LIST_DEPTH = ole_pkg::LIST_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ole_pkg::ACTION_W-1:0]        i_action,
    input  logic [ole_pkg::POS_W-1:0]           i_position,
    input  logic signed [ole_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ole_pkg::STATUS_W-1:0]        o_status,
    output logic [ole_pkg::RES_POS_W-1:0]       o_result_position,
    output logic [ole_pkg::COUNT_OUT_W-1:0]     o_entry_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ole_pkg::TOL_W-1:0]           i_cfg_match_tolerance
);

    import ole_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    ole_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_action   (i_action),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ole_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_match_tolerance (i_cfg_match_tolerance),
        .i_position            (i_position),
        .i_value               (i_value),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_status              (o_status),
        .o_result_position     (o_result_position),
        .o_entry_count         (o_entry_count)
    );

    assign o_cfg_ready = 1'b1;

endmodule
